// ===== hdl/fbd_pkg.sv =====
// shared types and constants of the rotated framebuffer draw engine
// no dependencies; imported by fbd_plot and the top level
package fbd_pkg;

    // coordinates carry one guard bit above the 12-bit command fields
    localparam int COORD_W = 13;
    // raster index before the store bound check: 9-bit row times 8-bit stride plus column
    localparam int IDX_W   = 18;

    typedef enum logic [1:0] {
        ACT_PLOT,
        ACT_LINE,
        ACT_RECT,
        ACT_READ
    } t_action;

    localparam logic [1:0] REG_ROTATION = 2'd0;
    localparam logic [1:0] REG_WIDTH    = 2'd1;
    localparam logic [1:0] REG_HEIGHT   = 2'd2;

    typedef struct packed {
        logic [1:0] rotation;
        logic [7:0] width;
        logic [8:0] height;
    } t_view_cfg;

    typedef struct packed {
        logic busy;
        logic wr_valid;
    } t_plot_status;

endpackage

// ===== hdl/rotated_framebuffer_draw_engine_unit.sv =====
// top level: stream ports, register port and command sequencer of the draw engine
// depends on fbd_pkg, fbd_plot and fbd_store
//
// One command at a time. A plot and a read give their result from the drain step. A
// line walks its major axis, one pixel per step (|dx| or |dy| plus one pixels), and a
// rectangle one pixel per step over its clipped area, each after its setup states; an
// empty rectangle goes from its clip state straight to the drain step.
// The pace is set by the single pixel unit, which maps and writes one pixel per
// cycle. A result waiting at the output does not hold off the next request; the
// sequencer holds at its drain step until the output register is free. After reset
// the store is swept to zero, one word per cycle over all MAX_WIDTH * MAX_HEIGHT words, and
// no request is taken until the sweep ends; register writes work throughout.
module rotated_framebuffer_draw_engine_unit #(
    parameter int MAX_WIDTH  = 240,
    parameter int MAX_HEIGHT = 320
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // tdata: x_a[11:0], y_a[23:12], x_b[35:24], y_b[47:36], rect_width[59:48],
    //        rect_height[71:60], color[87:72], read_index[104:88], zero fill
    input  logic [111:0]  s_axis_tdata,
    // tuser: action[1:0]
    input  logic [1:0]    s_axis_tuser,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: read_pixel[15:0], pixels_written[32:16], zero fill
    output logic [39:0]   m_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import fbd_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [7:0] WIDTH_RST  = 8'((240 > MAX_WIDTH) ? MAX_WIDTH : 240);
    localparam logic [8:0] HEIGHT_RST = 9'((320 > MAX_HEIGHT) ? MAX_HEIGHT : 320);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLOT,
        S_LINE_SWAP,
        S_LINE_PREP,
        S_LINE_RUN,
        S_RECT_SUM,
        S_RECT_CLIP,
        S_RECT_RUN,
        S_READ,
        S_DRAIN
    } t_state;

    // configuration
    logic [1:0]  r_rotation;
    logic [7:0]  r_width;
    logic [8:0]  r_height;
    logic        cfg_write;
    t_view_cfg   view_cfg;

    // command
    t_state              r_state;
    logic signed [12:0]  r_xa;
    logic signed [12:0]  r_ya;
    logic signed [12:0]  r_xb;
    logic signed [12:0]  r_yb;
    logic signed [11:0]  r_rw;
    logic signed [11:0]  r_rh;
    logic [15:0]         r_color;
    logic [16:0]         r_ridx;

    // walk state shared by line and rectangle
    logic signed [12:0]  r_x0;
    logic signed [12:0]  r_y0;
    logic signed [12:0]  r_x1;
    logic signed [12:0]  r_y1;
    logic signed [12:0]  r_rx0;
    logic [12:0]         r_dx;
    logic [12:0]         r_dy;
    logic signed [13:0]  r_err;
    logic                r_steep;
    logic                r_yup;
    logic                r_rd_ok;
    logic [16:0]         r_count;

    // result
    logic                r_m_valid;
    logic [15:0]         r_m_word;
    logic [16:0]         r_m_count;

    // combinational helpers
    logic [8:0]          view_w;
    logic [8:0]          view_h;
    logic signed [12:0]  vw13;
    logic signed [12:0]  vh13;
    logic signed [12:0]  dxa;
    logic signed [12:0]  dya;
    logic [12:0]         adx;
    logic [12:0]         ady;
    logic                steep;
    logic                back;
    logic signed [12:0]  ox0;
    logic signed [12:0]  oy0;
    logic signed [12:0]  ox1;
    logic signed [12:0]  oy1;
    logic signed [12:0]  ddx;
    logic signed [12:0]  ddy;
    logic signed [13:0]  e2;
    logic signed [12:0]  cx0;
    logic signed [12:0]  cy0;
    logic signed [12:0]  cxe;
    logic signed [12:0]  cye;
    logic                rect_none;
    logic                rd_in_range;
    logic                accept;
    logic                result_load;

    logic                plot_valid;
    logic signed [12:0]  plot_x;
    logic signed [12:0]  plot_y;
    t_plot_status        plot_st;
    logic [AW-1:0]       wr_addr;
    logic [15:0]         rd_data;
    logic                clr_busy;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= 2'd0;
            r_width    <= WIDTH_RST;
            r_height   <= HEIGHT_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_ROTATION: r_rotation <= pwdata[1:0];
                REG_WIDTH: begin
                    r_width <= (32'(pwdata[7:0]) > MAX_WIDTH) ? 8'(MAX_WIDTH) : pwdata[7:0];
                end
                REG_HEIGHT: begin
                    r_height <= (32'(pwdata[8:0]) > MAX_HEIGHT) ? 9'(MAX_HEIGHT)
                                                                : pwdata[8:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROTATION: prdata = {30'd0, r_rotation};
            REG_WIDTH:    prdata = {24'd0, r_width};
            REG_HEIGHT:   prdata = {23'd0, r_height};
            default:      prdata = 32'd0;
        endcase
    end

    assign view_cfg.rotation = r_rotation;
    assign view_cfg.width    = r_width;
    assign view_cfg.height   = r_height;

    assign view_w = r_rotation[0] ? r_height : {1'b0, r_width};
    assign view_h = r_rotation[0] ? {1'b0, r_width} : r_height;
    assign vw13   = $signed({4'b0000, view_w});
    assign vh13   = $signed({4'b0000, view_h});

    // ---------------- line setup ----------------
    assign dxa   = r_xb - r_xa;
    assign dya   = r_yb - r_ya;
    assign adx   = dxa[12] ? 13'(-dxa) : 13'(dxa);
    assign ady   = dya[12] ? 13'(-dya) : 13'(dya);
    assign steep = ady > adx;

    // lines running backwards swap their ends
    assign back = r_x0 > r_x1;
    assign ox0  = back ? r_x1 : r_x0;
    assign oy0  = back ? r_y1 : r_y0;
    assign ox1  = back ? r_x0 : r_x1;
    assign oy1  = back ? r_y0 : r_y1;
    assign ddx  = ox1 - ox0;
    assign ddy  = oy1 - oy0;

    assign e2 = r_err - $signed({1'b0, r_dy});

    // ---------------- rectangle clip ----------------
    assign cx0 = r_xa[12] ? 13'sd0 : r_xa;
    assign cy0 = r_ya[12] ? 13'sd0 : r_ya;
    assign cxe = (r_x1 > vw13) ? vw13 : r_x1;
    assign cye = (r_y1 > vh13) ? vh13 : r_y1;
    assign rect_none = r_rw[11] || (r_rw == 12'sd0) || r_rh[11] || (r_rh == 12'sd0)
                    || (cx0 >= cxe) || (cy0 >= cye);

    assign rd_in_range = 32'(r_ridx) < 32'(DEPTH);

    // ---------------- pixel requests ----------------
    always_comb begin
        plot_valid = 1'b0;
        plot_x     = r_x0;
        plot_y     = r_y0;
        case (r_state)
            S_PLOT: begin
                plot_valid = 1'b1;
                plot_x     = r_xa;
                plot_y     = r_ya;
            end
            S_LINE_RUN: begin
                plot_valid = 1'b1;
                plot_x     = r_steep ? r_y0 : r_x0;
                plot_y     = r_steep ? r_x0 : r_y0;
            end
            S_RECT_RUN: plot_valid = 1'b1;
            default: ;
        endcase
    end

    // ---------------- sequencer ----------------
    assign s_axis_tready = (r_state == S_IDLE) && !clr_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // last pixel has left the pixel unit and the output register is free
    assign result_load = (r_state == S_DRAIN) && !plot_st.busy && !plot_st.wr_valid
                      && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_count   <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (result_load) begin
                r_m_valid <= 1'b1;
                r_m_word  <= r_rd_ok ? rd_data : 16'h0000;
                r_m_count <= r_count;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (plot_st.wr_valid) begin
                r_count <= r_count + 17'd1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_count  <= '0;
                        r_rd_ok  <= 1'b0;
                        r_xa     <= {s_axis_tdata[11], s_axis_tdata[11:0]};
                        r_ya     <= {s_axis_tdata[23], s_axis_tdata[23:12]};
                        r_xb     <= {s_axis_tdata[35], s_axis_tdata[35:24]};
                        r_yb     <= {s_axis_tdata[47], s_axis_tdata[47:36]};
                        r_rw     <= s_axis_tdata[59:48];
                        r_rh     <= s_axis_tdata[71:60];
                        r_color  <= s_axis_tdata[87:72];
                        r_ridx   <= s_axis_tdata[104:88];
                        unique case (t_action'(s_axis_tuser))
                            ACT_PLOT: r_state <= S_PLOT;
                            ACT_LINE: r_state <= S_LINE_SWAP;
                            ACT_RECT: r_state <= S_RECT_SUM;
                            default:  r_state <= S_READ;
                        endcase
                    end
                end
                S_PLOT: r_state <= S_DRAIN;
                S_LINE_SWAP: begin
                    // steep lines walk along y
                    r_steep <= steep;
                    r_x0    <= steep ? r_ya : r_xa;
                    r_y0    <= steep ? r_xa : r_ya;
                    r_x1    <= steep ? r_yb : r_xb;
                    r_y1    <= steep ? r_xb : r_yb;
                    r_state <= S_LINE_PREP;
                end
                S_LINE_PREP: begin
                    r_x0    <= ox0;
                    r_y0    <= oy0;
                    r_x1    <= ox1;
                    r_dx    <= 13'(ddx);
                    r_dy    <= ddy[12] ? 13'(-ddy) : 13'(ddy);
                    r_err   <= {2'b00, ddx[12:1]};
                    r_yup   <= oy0 < oy1;
                    r_state <= S_LINE_RUN;
                end
                S_LINE_RUN: begin
                    if (e2 < 14'sd0) begin
                        r_err <= e2 + $signed({1'b0, r_dx});
                        r_y0  <= r_yup ? r_y0 + 13'sd1 : r_y0 - 13'sd1;
                    end else begin
                        r_err <= e2;
                    end
                    r_x0 <= r_x0 + 13'sd1;
                    if (r_x0 == r_x1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_RECT_SUM: begin
                    r_x1    <= r_xa + {r_rw[11], r_rw};
                    r_y1    <= r_ya + {r_rh[11], r_rh};
                    r_state <= S_RECT_CLIP;
                end
                S_RECT_CLIP: begin
                    r_x0  <= cx0;
                    r_rx0 <= cx0;
                    r_y0  <= cy0;
                    r_x1  <= cxe;
                    r_y1  <= cye;
                    r_state <= rect_none ? S_DRAIN : S_RECT_RUN;
                end
                S_RECT_RUN: begin
                    if ((r_x0 + 13'sd1) == r_x1) begin
                        r_x0 <= r_rx0;
                        r_y0 <= r_y0 + 13'sd1;
                        if ((r_y0 + 13'sd1) == r_y1) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_x0 <= r_x0 + 13'sd1;
                    end
                end
                S_READ: begin
                    r_rd_ok <= rd_in_range;
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    // wait for the last pixel to leave the pixel unit and for the output register to be free
                    if (result_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_m_count, r_m_word};

    // ---------------- submodules ----------------
    fbd_plot #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_plot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (view_cfg),
        .i_valid  (plot_valid),
        .i_x      (plot_x),
        .i_y      (plot_y),
        .o_status (plot_st),
        .o_addr   (wr_addr)
    );

    fbd_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (plot_st.wr_valid),
        .i_waddr    (wr_addr),
        .i_wdata    (r_color),
        .i_re       ((r_state == S_READ) && rd_in_range),
        .i_raddr    (AW'(r_ridx)),
        .o_rdata    (rd_data),
        .o_clr_busy (clr_busy)
    );

`ifndef NO_ASSERTIONS
    // no pixel write may land while the zero sweep owns the store
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !plot_st.wr_valid)
        else $error("pixel write during store clear");

    // a taken request always starts a command
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request taken but sequencer stayed idle");

    // a result appears only out of the drain step
    a_result_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_DRAIN))
        else $error("result raised outside drain");

    // a waiting result holds its data
    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while waiting");
`endif

endmodule

// ===== hdl/fbd_plot.sv =====
// pixel unit: canvas bound check, quarter-turn mapping and raster address
// depends on fbd_pkg; one pixel request per cycle, write request out of stage registers s1 then s2
module fbd_plot #(
    parameter int DEPTH = 76800,
    parameter int AW    = 17
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fbd_pkg::t_view_cfg          i_cfg,
    input  logic                        i_valid,
    input  logic signed [12:0]          i_x,
    input  logic signed [12:0]          i_y,
    output fbd_pkg::t_plot_status       o_status,
    output logic [AW-1:0]               o_addr
);
    import fbd_pkg::*;

    logic [8:0]               view_w;
    logic [8:0]               view_h;
    logic                     inside_view;
    logic [8:0]               xs;
    logic [8:0]               ys;
    logic [8:0]               wm1_x;
    logic [8:0]               wm1_y;
    logic [8:0]               hm1_x;
    logic [8:0]               hm1_y;
    logic [7:0]               sx;
    logic [8:0]               sy;
    logic [IDX_W-1:0]         idx;

    logic                     r_s1_valid;
    logic [7:0]               r_sx;
    logic [8:0]               r_sy;
    logic                     r_s2_valid;
    logic [IDX_W-1:0]         r_idx;

    assign view_w = i_cfg.rotation[0] ? i_cfg.height : {1'b0, i_cfg.width};
    assign view_h = i_cfg.rotation[0] ? {1'b0, i_cfg.width} : i_cfg.height;

    assign inside_view = !i_x[12] && !i_y[12]
                      && (i_x < $signed({4'b0000, view_w}))
                      && (i_y < $signed({4'b0000, view_h}));

    // inside the view both coordinates fit in nine bits
    assign xs    = i_x[8:0];
    assign ys    = i_y[8:0];
    assign wm1_x = {1'b0, i_cfg.width} - 9'd1 - xs;
    assign wm1_y = {1'b0, i_cfg.width} - 9'd1 - ys;
    assign hm1_x = i_cfg.height - 9'd1 - xs;
    assign hm1_y = i_cfg.height - 9'd1 - ys;

    always_comb begin
        case (i_cfg.rotation)
            2'd1: begin
                sx = wm1_y[7:0];
                sy = xs;
            end
            2'd2: begin
                sx = wm1_x[7:0];
                sy = hm1_y;
            end
            2'd3: begin
                sx = ys[7:0];
                sy = hm1_x;
            end
            default: begin
                sx = xs[7:0];
                sy = ys;
            end
        endcase
    end

    assign idx = IDX_W'(r_sy * i_cfg.width) + IDX_W'(r_sx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid && inside_view;
            r_s2_valid <= r_s1_valid;
        end
        r_sx  <= sx;
        r_sy  <= sy;
        r_idx <= idx;
    end

    assign o_status.wr_valid = r_s2_valid && (32'(r_idx) < 32'(DEPTH));
    assign o_status.busy     = r_s1_valid || r_s2_valid;
    assign o_addr            = AW'(r_idx);

endmodule

// ===== hdl/fbd_store.sv =====
// frame store: single write port, registered read port, zero sweep after reset
// no package dependencies
module fbd_store #(
    parameter int DEPTH = 76800,
    parameter int AW    = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata,
    output logic          o_clr_busy
);

    logic [15:0]   mem [DEPTH];
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= 16'h0000;
        end else if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

    assign o_clr_busy = r_clr_busy;

endmodule
